>>> hdl/timed_point_path_interpolator_defines.svh
// Assertion macros for the timed point path interpolator
`ifndef TIMED_POINT_PATH_INTERPOLATOR_DEFINES_SVH
`define TIMED_POINT_PATH_INTERPOLATOR_DEFINES_SVH
// condition holds in the same cycle as the trigger
`define TPPI_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("tppi check failed");
// condition holds in the cycle after the trigger
`define TPPI_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("tppi check failed");
`endif

>>> hdl/tppi_pkg.sv
// Shared types and constants for the timed point path interpolator
`timescale 1ns / 1ps
package tppi_pkg;
  localparam int NUM_FUTURE_POINTS = 2;
  localparam int FUT_LAST = NUM_FUTURE_POINTS - 1;
  localparam int ITER_W = $clog2(NUM_FUTURE_POINTS + 2);
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int NUM_AXES = 3;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_ADVANCE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic CFG_MAX_DELTA = 1'b0;
  localparam logic CFG_MOVE_EPS = 1'b1;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        point_time;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               point_on_floor;
    logic [31:0]        advance_period;
  } in_req_t;

  typedef struct packed {
    logic               eval_valid;
    logic signed [31:0] eval_x;
    logic signed [31:0] eval_y;
    logic signed [31:0] eval_z;
    logic               is_on_floor;
    logic               is_moving;
  } out_req_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_CAPTURE, OP_CLEAR, OP_ADD_PUT, OP_ADD_PULL, OP_ADV_ADD,
    OP_ADV_STEP, OP_ADV_FIN, OP_EV_INIT, OP_EV_DIV, OP_EV_MUL, OP_EV_ACC, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    logic       shift;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       last_eq_t;
    logic       last_eq_xyz;
    logic       t_le_now;
    logic       pull_ok;
    logic       period_zero;
    logic       cur_gt_now;
    logic       need_div;
    logic       out_free;
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_ADD_PUT, S_ADD_PULL, S_ADV_LOOP, S_EV_INIT, S_EV_DIV,
    S_EV_MUL, S_EV_ACC, S_OUT
  } state_t;
endpackage

>>> hdl/timed_point_path_interpolator.sv
// A request is decoded and evaluated; the weight needs the 16-step divider only on some requests.
// An add that writes the queue puts its point first; an advance adds the period, then steps points.
// An add that pulls the next point in evaluates twice, before and after the pull.
// One request at a time; the next request can be taken in the cycle its result is presented,
// and a stalled result holds back the next result. Synchronous active-low reset clears
// the path, the result valid and the registers (max_past_now_delta 0, move_epsilon 1).
`timescale 1ns / 1ps
`include "timed_point_path_interpolator_defines.svh"
module timed_point_path_interpolator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  tppi_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tppi_pkg::out_req_t out_data
);
  import tppi_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    busy;

  tppi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .busy     (busy),
    .st       (st),
    .cmd      (cmd)
  );

  tppi_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = busy;

  `TPPI_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
  `TPPI_ASSERT_SAME(a_result_ends_work, $rose(out_valid), !in_stall)
  `TPPI_ASSERT_SAME(a_capture_only_idle, cmd.op == OP_CAPTURE, !busy && in_valid)
endmodule

>>> hdl/tppi_ctrl.sv
// Sequencer for the timed point path interpolator
`timescale 1ns / 1ps
module tppi_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            busy,
  input  tppi_pkg::status_t st,
  output tppi_pkg::cmd_t  cmd
);
  import tppi_pkg::*;

  state_t               state_r, state_nxt;
  logic                 pull_r, pull_nxt;
  logic                 shift_r, shift_nxt;
  logic [ITER_W-1:0]    iter_r, iter_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]           axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pull_r  <= 1'b0;
      shift_r <= 1'b0;
      iter_r  <= '0;
      cnt_r   <= '0;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pull_r  <= pull_nxt;
      shift_r <= shift_nxt;
      iter_r  <= iter_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    pull_nxt  = pull_r;
    shift_nxt = shift_r;
    iter_nxt  = iter_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    cmd.op    = OP_NOP;
    cmd.axis  = axis_r;
    cmd.shift = shift_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_EV_INIT;
        pull_nxt  = 1'b0;
        priority case (st.func)
          FUNC_ADD: begin
            if (st.last_eq_t) begin
              // same time as the newest point: overwrite unless identical
              if (!st.last_eq_xyz) begin
                shift_nxt = 1'b0;
                state_nxt = S_ADD_PUT;
              end
            end else if (st.t_le_now) begin
              cmd.op = OP_CLEAR;
            end else if (st.pull_ok) begin
              pull_nxt  = 1'b1;
              shift_nxt = 1'b1;
            end else begin
              shift_nxt = 1'b1;
              state_nxt = S_ADD_PUT;
            end
          end
          FUNC_ADVANCE: begin
            if (!st.period_zero) begin
              cmd.op    = OP_ADV_ADD;
              iter_nxt  = '0;
              state_nxt = S_ADV_LOOP;
            end
          end
          FUNC_CLEAR: cmd.op = OP_CLEAR;
          default: ;
        endcase
      end
      S_ADD_PULL: begin
        cmd.op    = OP_ADD_PULL;
        pull_nxt  = 1'b0;
        state_nxt = S_ADD_PUT;
      end
      S_ADD_PUT: begin
        cmd.op    = OP_ADD_PUT;
        state_nxt = S_EV_INIT;
      end
      S_ADV_LOOP: begin
        if (st.cur_gt_now && (iter_r <= ITER_W'(NUM_FUTURE_POINTS))) begin
          cmd.op   = OP_ADV_STEP;
          iter_nxt = iter_r + 1'b1;
        end else begin
          cmd.op    = OP_ADV_FIN;
          state_nxt = S_EV_INIT;
        end
      end
      S_EV_INIT: begin
        cmd.op   = OP_EV_INIT;
        cnt_nxt  = '0;
        axis_nxt = '0;
        state_nxt = st.need_div ? S_EV_DIV : S_EV_MUL;
      end
      S_EV_DIV: begin
        cmd.op  = OP_EV_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = S_EV_MUL;
      end
      S_EV_MUL: begin
        cmd.op    = OP_EV_MUL;
        state_nxt = S_EV_ACC;
      end
      S_EV_ACC: begin
        cmd.op = OP_EV_ACC;
        if (axis_r == 2'(NUM_AXES - 1)) begin
          state_nxt = pull_r ? S_ADD_PULL : S_OUT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_EV_MUL;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

>>> hdl/tppi_dp.sv
// Path state, divider, multiplier and result register
`timescale 1ns / 1ps
module tppi_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [31:0]        cfg_wdata,
  input  tppi_pkg::in_req_t  in_data,
  input  tppi_pkg::cmd_t     cmd,
  output tppi_pkg::status_t  st,
  output logic               out_valid,
  input  logic               out_stall,
  output tppi_pkg::out_req_t out_data
);
  import tppi_pkg::*;

  logic [31:0]        max_delta_r;
  logic [30:0]        move_eps_r;
  in_req_t            req_r;
  logic [31:0]        fut_t_r [NUM_FUTURE_POINTS];
  logic signed [31:0] fut_p_r [NUM_FUTURE_POINTS][NUM_AXES];
  logic               fut_f_r [NUM_FUTURE_POINTS];
  logic [31:0]        past_t_r, now_t_r, cur_r;
  logic signed [31:0] past_p_r [NUM_AXES];
  logic signed [31:0] now_p_r [NUM_AXES];
  logic               past_f_r, now_f_r;
  logic [31:0]        span_r, rem_r;
  logic [16:0]        w_r;
  logic signed [50:0] prod_r;
  logic signed [31:0] res_r [NUM_AXES];
  out_req_t           out_r;
  logic               out_valid_r;

  logic               valid_path;
  logic signed [31:0] pt_p [NUM_AXES];
  logic [32:0]        div_sh;
  logic [32:0]        adv_sum;
  logic signed [34:0] pull_t;
  logic [31:0]        pull_sat;
  logic               pick_found;
  logic [31:0]        pick_t;
  logic signed [31:0] pick_p [NUM_AXES];
  logic               pick_f;
  logic [31:0]        fin_past;
  logic signed [32:0] diff_p;
  logic signed [32:0] acc_v;
  logic               far_any;
  logic signed [32:0] ad;

  assign valid_path = (past_t_r != '0) && (now_t_r != '0);
  assign pt_p[0] = req_r.point_x;
  assign pt_p[1] = req_r.point_y;
  assign pt_p[2] = req_r.point_z;

  always_comb begin
    st.func        = req_r.func;
    st.last_eq_t   = (fut_t_r[FUT_LAST] == req_r.point_time);
    st.last_eq_xyz = (fut_p_r[FUT_LAST][0] == pt_p[0]) && (fut_p_r[FUT_LAST][1] == pt_p[1])
                     && (fut_p_r[FUT_LAST][2] == pt_p[2]);
    st.t_le_now    = (req_r.point_time <= now_t_r);
    st.pull_ok     = valid_path && (fut_t_r[0] > now_t_r);
    st.period_zero = (req_r.advance_period == '0);
    st.cur_gt_now  = (cur_r > now_t_r);
    st.need_div    = valid_path && (cur_r >= past_t_r) && (cur_r < now_t_r);
    st.out_free    = !out_valid_r || !out_stall;
  end

  // first future point later than now
  always_comb begin
    pick_found = 1'b0;
    pick_t     = '0;
    pick_f     = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) pick_p[a] = '0;
    for (int i = NUM_FUTURE_POINTS - 1; i >= 0; i--) begin
      if (fut_t_r[i] > now_t_r) begin
        pick_found = 1'b1;
        pick_t     = fut_t_r[i];
        pick_f     = fut_f_r[i];
        for (int a = 0; a < NUM_AXES; a++) pick_p[a] = fut_p_r[i][a];
      end
    end
  end

  always_comb begin
    div_sh   = {rem_r, 1'b0};
    adv_sum  = {1'b0, cur_r} + {1'b0, req_r.advance_period};
    pull_t   = $signed({3'b0, fut_t_r[0]}) - $signed({3'b0, now_t_r})
               + $signed({3'b0, cur_r});
    if (pull_t < 0) pull_sat = '0;
    else if (pull_t > $signed({3'b0, 32'hFFFF_FFFF})) pull_sat = 32'hFFFF_FFFF;
    else pull_sat = pull_t[31:0];
    fin_past = past_t_r;
    if ((max_delta_r != '0) && (now_t_r > past_t_r)
        && ((now_t_r - past_t_r) > max_delta_r)) fin_past = now_t_r;
    diff_p = {now_p_r[cmd.axis][31], now_p_r[cmd.axis]}
             - {past_p_r[cmd.axis][31], past_p_r[cmd.axis]};
    acc_v  = {past_p_r[cmd.axis][31], past_p_r[cmd.axis]} + 33'(prod_r >>> 16);
  end

  always_comb begin
    far_any = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      ad = {now_p_r[a][31], now_p_r[a]} - {past_p_r[a][31], past_p_r[a]};
      if (ad < 0) ad = -ad;
      if (ad > $signed({2'b0, move_eps_r})) far_any = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delta_r <= '0;
      move_eps_r  <= 31'd1;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_MAX_DELTA) max_delta_r <= cfg_wdata;
      else move_eps_r <= cfg_wdata[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.op == OP_CLEAR)) begin
      for (int i = 0; i < NUM_FUTURE_POINTS; i++) begin
        fut_t_r[i] <= '0;
        fut_f_r[i] <= 1'b0;
        for (int a = 0; a < NUM_AXES; a++) fut_p_r[i][a] <= '0;
      end
      for (int a = 0; a < NUM_AXES; a++) begin
        past_p_r[a] <= '0;
        now_p_r[a]  <= '0;
      end
      past_t_r <= '0;
      now_t_r  <= '0;
      cur_r    <= '0;
      past_f_r <= 1'b0;
      now_f_r  <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_ADD_PUT: begin
          if (cmd.shift) begin
            for (int i = 0; i < FUT_LAST; i++) begin
              fut_t_r[i] <= fut_t_r[i+1];
              fut_f_r[i] <= fut_f_r[i+1];
              for (int a = 0; a < NUM_AXES; a++) fut_p_r[i][a] <= fut_p_r[i+1][a];
            end
          end
          fut_t_r[FUT_LAST] <= req_r.point_time;
          fut_f_r[FUT_LAST] <= req_r.point_on_floor;
          for (int a = 0; a < NUM_AXES; a++) fut_p_r[FUT_LAST][a] <= pt_p[a];
          if (now_t_r == '0) begin
            cur_r    <= req_r.point_time;
            now_t_r  <= req_r.point_time;
            past_t_r <= req_r.point_time;
            now_f_r  <= req_r.point_on_floor;
            past_f_r <= req_r.point_on_floor;
            for (int a = 0; a < NUM_AXES; a++) begin
              now_p_r[a]  <= pt_p[a];
              past_p_r[a] <= pt_p[a];
            end
          end
        end
        OP_ADD_PULL: begin
          past_t_r <= pull_sat;
          cur_r    <= pull_sat;
          now_t_r  <= fut_t_r[0];
          now_f_r  <= fut_f_r[0];
          for (int a = 0; a < NUM_AXES; a++) begin
            past_p_r[a] <= res_r[a];
            now_p_r[a]  <= fut_p_r[0][a];
          end
        end
        OP_ADV_ADD: cur_r <= adv_sum[32] ? 32'hFFFF_FFFF : adv_sum[31:0];
        OP_ADV_STEP: begin
          past_t_r <= now_t_r;
          past_f_r <= now_f_r;
          for (int a = 0; a < NUM_AXES; a++) past_p_r[a] <= now_p_r[a];
          if (pick_found) begin
            now_t_r <= pick_t;
            now_f_r <= pick_f;
            for (int a = 0; a < NUM_AXES; a++) now_p_r[a] <= pick_p[a];
          end else begin
            cur_r <= now_t_r;
          end
        end
        OP_ADV_FIN: begin
          past_t_r <= fin_past;
          if (cur_r < fin_past) cur_r <= fin_past;
        end
        default: ;
      endcase
    end
  end

  // capture, division and multiply-accumulate registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: req_r <= in_data;
      OP_EV_INIT: begin
        span_r <= now_t_r - past_t_r;
        rem_r  <= cur_r - past_t_r;
        if (!valid_path || (cur_r < past_t_r)) w_r <= '0;
        else if ((now_t_r <= past_t_r) || (cur_r >= now_t_r)) w_r <= 17'h10000;
        else w_r <= '0;
      end
      OP_EV_DIV: begin
        if (div_sh >= {1'b0, span_r}) begin
          rem_r <= 32'(div_sh - {1'b0, span_r});
          w_r   <= {1'b0, w_r[14:0], 1'b1};
        end else begin
          rem_r <= div_sh[31:0];
          w_r   <= {1'b0, w_r[14:0], 1'b0};
        end
      end
      OP_EV_MUL: prod_r <= 51'(diff_p * $signed({1'b0, w_r}));
      OP_EV_ACC: res_r[cmd.axis] <= acc_v[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_r.eval_valid  <= valid_path;
      out_r.eval_x      <= valid_path ? res_r[0] : '0;
      out_r.eval_y      <= valid_path ? res_r[1] : '0;
      out_r.eval_z      <= valid_path ? res_r[2] : '0;
      out_r.is_on_floor <= valid_path && past_f_r && now_f_r;
      out_r.is_moving   <= (cur_r >= past_t_r) && (cur_r <= now_t_r)
                           && (past_t_r < now_t_r) && far_any;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
